// ===== rtl/deq_pkg.sv =====
// Shared codes and types for the double-ended queue.
package deq_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_QUERY      = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } st_t;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int IN_W    = ((MODE_W + VALUE_W + 7) / 8) * 8;

endpackage

// ===== rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed words held in a ring memory.
//
//  channel | direction | handshake         | contents
//  s_*     | in        | s_tvalid/s_tready | one operation item (mode, value)
//  m_*     | out       | m_tvalid/m_tready | one result item per operation
//
// Each item runs in order: the accept edge updates the indexes and
// writes the ring, the next edge reads front and rear entries from the two
// ring copies, and the result is then offered in ST_OUT and held until
// taken. A stalled result blocks the next item. Reset clears the indexes
// and the count; the ring contents need no clearing.
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((deq_pkg::STAT_W + 2 * deq_pkg::VALUE_W + CW + 1 + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [deq_pkg::IN_W-1:0] s_tdata,   // mode[2:0], value[34:3]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_W-1:0]         m_tdata    // status, front_value, rear_value,
                                              // item_count, is_empty
);

  import deq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIDE = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int PAD  = OUT_W - (STAT_W + 2 * VALUE_W + CW + 1);

  st_t            state, state_next;
  logic [AW-1:0]  head, head_next;
  logic [AW-1:0]  tail, tail_next;
  logic [CW-1:0]  count, count_next;
  status_t        status_q, status_next;

  logic                  accept_in;
  mode_t                 mode;
  logic signed [VALUE_W-1:0] value;
  logic signed [WIDE-1:0]    value_wide;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  re;
  logic [AW-1:0]         rear_addr;
  logic [DATA_WIDTH-1:0] front_raw, rear_raw;
  logic signed [DATA_WIDTH-1:0] front_s, rear_s;
  logic signed [WIDE-1:0]       front_wide, rear_wide;
  logic [VALUE_W-1:0]    front_out, rear_out;
  logic                  full, empty;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : AW'(i + 1'b1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : AW'(i - 1'b1);
  endfunction

  assign mode       = mode_t'(s_tdata[MODE_W-1:0]);
  assign value      = s_tdata[MODE_W +: VALUE_W];
  assign value_wide = WIDE'(value);
  assign s_tready   = (state == ST_IDLE);
  assign accept_in  = s_tvalid & s_tready;
  assign full       = (count == CW'(DEPTH));
  assign empty      = (count == '0);

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = status_q;
    we          = 1'b0;
    waddr       = tail;
    unique case (state)
      ST_IDLE: begin
        if (accept_in) begin
          state_next  = ST_READ;
          status_next = STAT_DONE;
          case (mode)
            MODE_PUSH_FRONT: begin
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                head_next  = idx_dec(head);
                waddr      = idx_dec(head);
                we         = 1'b1;
                count_next = CW'(count + 1'b1);
              end
            end
            MODE_PUSH_REAR: begin
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                tail_next  = idx_inc(tail);
                waddr      = tail;
                we         = 1'b1;
                count_next = CW'(count + 1'b1);
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                head_next  = idx_inc(head);
                count_next = CW'(count - 1'b1);
              end
            end
            MODE_POP_REAR: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                tail_next  = idx_dec(tail);
                count_next = CW'(count - 1'b1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      status_q <= STAT_DONE;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      status_q <= status_next;
    end
  end

  assign re        = (state == ST_READ);
  assign rear_addr = idx_dec(tail);

  deq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_front_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(value_wide[DATA_WIDTH-1:0]),
    .re   (re),
    .raddr(head),
    .rdata(front_raw)
  );

  deq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_rear_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(value_wide[DATA_WIDTH-1:0]),
    .re   (re),
    .raddr(rear_addr),
    .rdata(rear_raw)
  );

  assign front_s    = front_raw;
  assign rear_s     = rear_raw;
  assign front_wide = WIDE'(front_s);
  assign rear_wide  = WIDE'(rear_s);
  assign front_out  = empty ? '1 : front_wide[VALUE_W-1:0];
  assign rear_out   = empty ? '1 : rear_wide[VALUE_W-1:0];

  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {{PAD{1'b0}}, empty, count, rear_out, front_out, status_q};

endmodule
